/* hw/rtl/klv_local_set_parser_defines.svh */
// ----------------------------------------------------------------------------
// klv local set parser assertion macros
// shared assertion forms for the parser rtl
// ----------------------------------------------------------------------------
`ifndef KLV_LOCAL_SET_PARSER_DEFINES_SVH
`define KLV_LOCAL_SET_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KLVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define KLVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/klvp_pkg.sv */
// ----------------------------------------------------------------------------
// klvp_pkg
// types, constants and codes shared by the klv local set parser
// ----------------------------------------------------------------------------
package klvp_pkg;

   localparam int KEY_BYTES         = 16;
   localparam int KEY_CNT_W         = $clog2(KEY_BYTES);
   localparam int MAX_BER_BYTES_DEF = 8;

   localparam logic [KEY_CNT_W-1:0] KEY_LAST = KEY_CNT_W'(KEY_BYTES - 1);

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_UPPER     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOWER     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKSUM_TAG  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMESTAMP_TAG = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION_TAG   = 3'd4;

   localparam logic [7:0] CHECKSUM_TAG_RST  = 8'd1;
   localparam logic [7:0] TIMESTAMP_TAG_RST = 8'd2;
   localparam logic [7:0] VERSION_TAG_RST   = 8'd65;

   // packet status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_WRONG_KEY    = 3'd1;
   localparam logic [2:0] ST_NO_TIMESTAMP = 3'd2;
   localparam logic [2:0] ST_NO_VERSION   = 3'd3;
   localparam logic [2:0] ST_NO_CHECKSUM  = 3'd4;
   localparam logic [2:0] ST_BAD_CHECKSUM = 3'd5;
   localparam logic [2:0] ST_TRUNCATED    = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic       value_valid;
      logic [7:0] item_tag;
      logic [7:0] value_offset;
      logic [7:0] value_data;
      logic       item_last;
      logic       packet_done;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_upper;
      logic [63:0] key_lower;
      logic [7:0]  checksum_tag;
      logic [7:0]  timestamp_tag;
      logic [7:0]  version_tag;
   } cfg_type;

endpackage

/* hw/rtl/klv_local_set_parser.sv */
// path: a byte is held in the input register until the parse step, and its result
// is captured in the result register; rsp back-pressure can hold the byte in the input
// register and the result in the result register
// throughput: one byte per cycle while rsp back-pressure does not stall the result register,
// set by the combinational parse step between the input register and the result register
// reset: synchronous, active high; returns to the key phase with default tags
// ----------------------------------------------------------------------------
// klv_local_set_parser
// byte-serial klv local set parser with key check, item split and checksum
// ----------------------------------------------------------------------------
`include "klv_local_set_parser_defines.svh"

module klv_local_set_parser #(
   parameter int MAX_BER_BYTES = klvp_pkg::MAX_BER_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // byte input channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  klvp_pkg::req_type                req_data,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output klvp_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                             csr_we,
   input  logic [klvp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [klvp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import klvp_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    req_take;
   logic    step;
   logic    parse_valid;
   rsp_type parse_result;
   cfg_type cfg;

   // the held byte is parsed once the result register is free or draining;
   // a byte that gives no result still waits for that, which keeps order simple
   assign step     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // result register refills in the same cycle its transaction completes
   always_comb begin
      if (step) begin
         out_valid_in = parse_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (step && parse_valid) begin
         out_data_ff <= parse_result;
      end
   end

   klvp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   klvp_parse #(
      .MAX_BER_BYTES (MAX_BER_BYTES)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (in_item_ff),
      .cfg          (cfg),
      .result_valid (parse_valid),
      .result       (parse_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // every result carries either a value byte or a status
   `KLVP_ASSERT_NOW(a_rsp_not_empty, clock, reset, rsp_valid, rsp_data.value_valid || rsp_data.packet_done, "result with neither value nor status")
   // status is only non-zero on a packet end
   `KLVP_ASSERT_NOW(a_status_with_done, clock, reset, rsp_valid && !rsp_data.packet_done, rsp_data.status == ST_OK, "status without packet end")
   // a held byte is never overwritten before it is parsed
   `KLVP_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !step, in_valid_ff && $stable(in_item_ff), "input register lost a byte")
   // the result register only fills from a parse step
   `KLVP_ASSERT_NOW(a_out_fill, clock, reset, $rose(out_valid_ff), $past(step), "result register filled without a parse step")

endmodule

/* hw/rtl/klvp_csr.sv */
// ----------------------------------------------------------------------------
// klvp_csr
// configuration registers: universal key and the three special tag numbers
// ----------------------------------------------------------------------------
module klvp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [klvp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [klvp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output klvp_pkg::cfg_type                  cfg
);
   import klvp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_UPPER:     cfg_in.key_upper     = csr_wdata;
            CSR_KEY_LOWER:     cfg_in.key_lower     = csr_wdata;
            CSR_CHECKSUM_TAG:  cfg_in.checksum_tag  = csr_wdata[7:0];
            CSR_TIMESTAMP_TAG: cfg_in.timestamp_tag = csr_wdata[7:0];
            CSR_VERSION_TAG:   cfg_in.version_tag   = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_upper     <= '0;
         cfg_ff.key_lower     <= '0;
         cfg_ff.checksum_tag  <= CHECKSUM_TAG_RST;
         cfg_ff.timestamp_tag <= TIMESTAMP_TAG_RST;
         cfg_ff.version_tag   <= VERSION_TAG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/klvp_parse.sv */
// ----------------------------------------------------------------------------
// klvp_parse
// per-byte parse state: key check, ber skip, tag/length/value split,
// running checksum and end-of-packet status
// ----------------------------------------------------------------------------
module klvp_parse #(
   parameter int MAX_BER_BYTES = klvp_pkg::MAX_BER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  klvp_pkg::req_type item,
   input  klvp_pkg::cfg_type cfg,
   output logic              result_valid,
   output klvp_pkg::rsp_type result
);
   import klvp_pkg::*;

   localparam int BER_W = $clog2(MAX_BER_BYTES + 1);
   localparam logic [6:0] BER_MAX = 7'(MAX_BER_BYTES);

   localparam logic [2:0] PH_KEY       = 3'd0;
   localparam logic [2:0] PH_BER_FIRST = 3'd1;
   localparam logic [2:0] PH_BER_MORE  = 3'd2;
   localparam logic [2:0] PH_TAG       = 3'd3;
   localparam logic [2:0] PH_LEN       = 3'd4;
   localparam logic [2:0] PH_VALUE     = 3'd5;

   logic [2:0]           phase_ff,          phase_in;
   logic [KEY_CNT_W-1:0] byte_count_ff,     byte_count_in;
   logic [BER_W-1:0]     ber_left_ff,       ber_left_in;
   logic [7:0]           current_tag_ff,    current_tag_in;
   logic [7:0]           current_length_ff, current_length_in;
   logic [7:0]           value_count_ff,    value_count_in;
   logic [15:0]          running_sum_ff,    running_sum_in;
   logic                 position_odd_ff,   position_odd_in;
   logic [15:0]          received_sum_ff,   received_sum_in;
   logic                 seen_timestamp_ff, seen_timestamp_in;
   logic                 seen_version_ff,   seen_version_in;
   logic                 discarding_ff,     discarding_in;

   logic [8*KEY_BYTES-1:0] key_all;
   logic [7:0]             key_byte;
   logic [7:0]             b;
   logic                   fin;
   logic [15:0]            sum_plus;
   logic [7:0]             value_count_inc;
   logic [BER_W-1:0]       ber_dec;
   logic                   clear_pkt;

   assign b   = item.data_byte;
   assign fin = item.final_byte;

   // key byte k sits at the top for k = 0
   assign key_all  = {cfg.key_upper, cfg.key_lower};
   assign key_byte = key_all[{~byte_count_ff, 3'b000} +: 8];

   // even positions weigh the byte as the high half
   assign sum_plus        = running_sum_ff + (position_odd_ff ? {8'h00, b} : {b, 8'h00});
   assign value_count_inc = value_count_ff + 8'd1;
   assign ber_dec         = ber_left_ff - BER_W'(1);

   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      ber_left_in       = ber_left_ff;
      current_tag_in    = current_tag_ff;
      current_length_in = current_length_ff;
      value_count_in    = value_count_ff;
      running_sum_in    = running_sum_ff;
      position_odd_in   = position_odd_ff;
      received_sum_in   = received_sum_ff;
      seen_timestamp_in = seen_timestamp_ff;
      seen_version_in   = seen_version_ff;
      discarding_in     = discarding_ff;
      result_valid      = 1'b0;
      result            = '0;
      clear_pkt         = 1'b0;

      if (discarding_ff) begin
         // rest of packet ignored; after a key mismatch the end stays silent
         if (fin) begin
            clear_pkt = 1'b1;
            if (phase_ff != PH_KEY) begin
               result_valid       = 1'b1;
               result.packet_done = 1'b1;
               result.status      = ST_TRUNCATED;
            end
         end
      end else if (phase_ff == PH_KEY && b != key_byte) begin
         if (fin) begin
            clear_pkt = 1'b1;
         end else begin
            discarding_in = 1'b1;
         end
         result_valid       = 1'b1;
         result.packet_done = 1'b1;
         result.status      = ST_WRONG_KEY;
      end else begin
         position_odd_in = ~position_odd_ff;
         unique case (phase_ff)
            PH_KEY: begin
               running_sum_in = sum_plus;
               if (byte_count_ff == KEY_LAST) begin
                  byte_count_in = '0;
                  phase_in      = PH_BER_FIRST;
               end else begin
                  byte_count_in = byte_count_ff + KEY_CNT_W'(1);
               end
            end
            PH_BER_FIRST: begin
               running_sum_in = sum_plus;
               if (!b[7] || b[6:0] == 7'd0) begin
                  phase_in = PH_TAG;
               end else if (b[6:0] > BER_MAX) begin
                  phase_in      = PH_BER_MORE;
                  discarding_in = 1'b1;
               end else begin
                  ber_left_in = b[BER_W-1:0];
                  phase_in    = PH_BER_MORE;
               end
            end
            PH_BER_MORE: begin
               running_sum_in = sum_plus;
               ber_left_in    = ber_dec;
               if (ber_dec == '0) begin
                  phase_in = PH_TAG;
               end
            end
            PH_TAG: begin
               running_sum_in = sum_plus;
               current_tag_in = b;
               if (b == cfg.timestamp_tag) begin
                  seen_timestamp_in = 1'b1;
               end
               if (b == cfg.version_tag) begin
                  seen_version_in = 1'b1;
               end
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               running_sum_in    = sum_plus;
               current_length_in = b;
               value_count_in    = '0;
               phase_in          = (b == 8'd0) ? PH_TAG : PH_VALUE;
            end
            default: begin
               // value byte; checksum item bytes shift into the received sum
               if (current_tag_ff == cfg.checksum_tag) begin
                  received_sum_in = {received_sum_ff[7:0], b};
               end else begin
                  running_sum_in = sum_plus;
               end
               result.value_valid  = 1'b1;
               result.item_tag     = current_tag_ff;
               result.value_offset = value_count_ff;
               result.value_data   = b;
               value_count_in      = value_count_inc;
               if (value_count_inc >= current_length_ff) begin
                  result.item_last = 1'b1;
                  phase_in         = PH_TAG;
               end
            end
         endcase

         if (fin) begin
            clear_pkt          = 1'b1;
            result_valid       = 1'b1;
            result.packet_done = 1'b1;
            if (discarding_in || phase_in != PH_TAG) begin
               result.status = ST_TRUNCATED;
            end else if (!seen_timestamp_in) begin
               result.status = ST_NO_TIMESTAMP;
            end else if (!seen_version_in) begin
               result.status = ST_NO_VERSION;
            end else if (received_sum_in == 16'd0) begin
               result.status = ST_NO_CHECKSUM;
            end else if (received_sum_in != running_sum_in) begin
               result.status = ST_BAD_CHECKSUM;
            end else begin
               result.status = ST_OK;
            end
         end else begin
            result_valid = result.value_valid;
         end
      end

      if (clear_pkt) begin
         phase_in          = PH_KEY;
         byte_count_in     = '0;
         ber_left_in       = '0;
         current_tag_in    = '0;
         current_length_in = '0;
         value_count_in    = '0;
         running_sum_in    = '0;
         position_odd_in   = 1'b0;
         received_sum_in   = '0;
         seen_timestamp_in = 1'b0;
         seen_version_in   = 1'b0;
         discarding_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_KEY;
         byte_count_ff     <= '0;
         ber_left_ff       <= '0;
         current_tag_ff    <= '0;
         current_length_ff <= '0;
         value_count_ff    <= '0;
         running_sum_ff    <= '0;
         position_odd_ff   <= 1'b0;
         received_sum_ff   <= '0;
         seen_timestamp_ff <= 1'b0;
         seen_version_ff   <= 1'b0;
         discarding_ff     <= 1'b0;
      end else if (step) begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         ber_left_ff       <= ber_left_in;
         current_tag_ff    <= current_tag_in;
         current_length_ff <= current_length_in;
         value_count_ff    <= value_count_in;
         running_sum_ff    <= running_sum_in;
         position_odd_ff   <= position_odd_in;
         received_sum_ff   <= received_sum_in;
         seen_timestamp_ff <= seen_timestamp_in;
         seen_version_ff   <= seen_version_in;
         discarding_ff     <= discarding_in;
      end
   end

endmodule

/* tb/sv/tb_klv_local_set_parser.sv */
// ----------------------------------------------------------------------------
// tb_klv_local_set_parser
// self-checking bench for the byte-serial klv local set parser: packets are
// built from the current key and tag registers, sent a byte per transaction,
// and every result is checked against an in-bench parse of the same bytes
// ----------------------------------------------------------------------------
module tb_klv_local_set_parser;
   import klvp_pkg::*;

   // cycles with no transaction on either channel before the run is abandoned
   localparam int QUIET_LIMIT   = 500;
   // settling time after the last awaited result arrives
   localparam int SETTLE_CYCLES = 4;
   // bytes of well-formed random packets to send
   localparam int RANDOM_BYTES  = 200;
   // the last stretch of the random part runs with no idling at all
   localparam int CALM_BYTES    = 60;

   // where the parse stands inside the current packet
   typedef enum logic [2:0] {
      STG_KEY,
      STG_BER_FIRST,
      STG_BER_MORE,
      STG_TAG,
      STG_LEN,
      STG_VALUE
   } parse_stage_type;

   // kinds of item placed in a random packet
   typedef enum int {
      ITEM_TIMESTAMP,
      ITEM_VERSION,
      ITEM_OTHER,
      ITEM_CHECKSUM
   } item_kind_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // register copy as the block should hold it
   cfg_type shadow_cfg;

   // parse state of the packet in flight
   parse_stage_type       stage;
   logic [KEY_CNT_W-1:0]  key_idx;
   logic [3:0]            ber_left;
   logic [7:0]            cur_tag;
   logic [7:0]            cur_len;
   logic [7:0]            value_idx;
   logic [15:0]           running_sum;
   logic [15:0]           received_sum;
   logic                  odd_pos;
   logic                  seen_ts;
   logic                  seen_ver;
   logic                  skip_rest;

   rsp_type    expected_rsp[$];
   logic [7:0] pkt[$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   logic       idle_on = 1'b1;

   klv_local_set_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // packet parse, one accepted byte at a time
   // ---------------------------------------------------------------------------

   // key byte k, byte 0 in the top bits of key_upper
   function automatic logic [7:0] key_byte(input int k);
      if (k < 8) return shadow_cfg.key_upper[8*(7-k) +: 8];
      return shadow_cfg.key_lower[8*(15-k) +: 8];
   endfunction

   function automatic void clear_packet();
      stage        = STG_KEY;
      key_idx      = '0;
      ber_left     = '0;
      cur_tag      = '0;
      cur_len      = '0;
      value_idx    = '0;
      running_sum  = '0;
      received_sum = '0;
      odd_pos      = 1'b0;
      seen_ts      = 1'b0;
      seen_ver     = 1'b0;
      skip_rest    = 1'b0;
   endfunction

   // even positions go into the high byte of the sum
   function automatic void add_to_sum(input logic [7:0] b);
      if (odd_pos) running_sum = running_sum + {8'h00, b};
      else running_sum = running_sum + {b, 8'h00};
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic fin);
      rsp_type r;
      logic    key_fail;
      r = '0;
      // rest of a rejected packet: only an over-long length reports on its last byte
      if (skip_rest) begin
         if (fin) begin
            key_fail = (stage == STG_KEY);
            clear_packet();
            if (!key_fail) begin
               r.packet_done = 1'b1;
               r.status      = ST_TRUNCATED;
               expected_rsp.push_back(r);
            end
         end
         return;
      end
      case (stage)
         STG_KEY: begin
            if (b != key_byte(key_idx)) begin
               // wrong key is reported at once
               if (fin) clear_packet();
               else skip_rest = 1'b1;
               r.packet_done = 1'b1;
               r.status      = ST_WRONG_KEY;
               expected_rsp.push_back(r);
               return;
            end
            add_to_sum(b);
            if (key_idx == KEY_LAST) begin
               key_idx = '0;
               stage   = STG_BER_FIRST;
            end else begin
               key_idx = key_idx + 1'b1;
            end
         end
         STG_BER_FIRST: begin
            add_to_sum(b);
            if (!b[7] || b[6:0] == 7'd0) begin
               stage = STG_TAG;
            end else if (b[6:0] > MAX_BER_BYTES_DEF) begin
               stage     = STG_BER_MORE;
               skip_rest = 1'b1;
            end else begin
               ber_left = b[3:0];
               stage    = STG_BER_MORE;
            end
         end
         STG_BER_MORE: begin
            add_to_sum(b);
            ber_left = ber_left - 1'b1;
            if (ber_left == 4'd0) stage = STG_TAG;
         end
         STG_TAG: begin
            add_to_sum(b);
            cur_tag = b;
            if (b == shadow_cfg.timestamp_tag) seen_ts = 1'b1;
            if (b == shadow_cfg.version_tag) seen_ver = 1'b1;
            stage = STG_LEN;
         end
         STG_LEN: begin
            add_to_sum(b);
            cur_len   = b;
            value_idx = '0;
            if (b == 8'd0) stage = STG_TAG;
            else stage = STG_VALUE;
         end
         default: begin
            // checksum values shift into the received sum instead of the running one
            if (cur_tag == shadow_cfg.checksum_tag) received_sum = {received_sum[7:0], b};
            else add_to_sum(b);
            r.value_valid  = 1'b1;
            r.item_tag     = cur_tag;
            r.value_offset = value_idx;
            r.value_data   = b;
            value_idx      = value_idx + 1'b1;
            if (value_idx >= cur_len) begin
               r.item_last = 1'b1;
               stage       = STG_TAG;
            end
         end
      endcase
      odd_pos = ~odd_pos;
      if (fin) begin
         r.packet_done = 1'b1;
         if (skip_rest || stage != STG_TAG) r.status = ST_TRUNCATED;
         else if (!seen_ts) r.status = ST_NO_TIMESTAMP;
         else if (!seen_ver) r.status = ST_NO_VERSION;
         else if (received_sum == 16'd0) r.status = ST_NO_CHECKSUM;
         else if (received_sum != running_sum) r.status = ST_BAD_CHECKSUM;
         else r.status = ST_OK;
         clear_packet();
         expected_rsp.push_back(r);
      end else if (r.value_valid) begin
         expected_rsp.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // packet building
   // ---------------------------------------------------------------------------

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // key from the current registers, then the ber length and its extra bytes
   function automatic void begin_packet(input logic [7:0] ber);
      int k;
      int extra;
      pkt.delete();
      for (k = 0; k < KEY_BYTES; k++) pkt.push_back(key_byte(k));
      pkt.push_back(ber);
      extra = (ber[7] && ber[6:0] <= MAX_BER_BYTES_DEF) ? int'(ber[6:0]) : 0;
      repeat (extra) pkt.push_back(rand_byte());
   endfunction

   function automatic void add_item(input logic [7:0] tag, input int len);
      pkt.push_back(tag);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(rand_byte());
   endfunction

   function automatic void add_mandatory();
      add_item(shadow_cfg.timestamp_tag, 8);
      add_item(shadow_cfg.version_tag, 1);
   endfunction

   // two-byte checksum item matching every byte placed so far
   function automatic void add_checksum();
      logic [15:0] acc;
      int          i;
      pkt.push_back(shadow_cfg.checksum_tag);
      pkt.push_back(8'd2);
      acc = '0;
      for (i = 0; i < pkt.size(); i++)
         acc = acc + ((i % 2 == 0) ? {pkt[i], 8'h00} : {8'h00, pkt[i]});
      pkt.push_back(acc[15:8]);
      pkt.push_back(acc[7:0]);
   endfunction

   function automatic int rand_len();
      if ($urandom_range(0, 7) == 0) return $urandom_range(8, 24);
      return $urandom_range(0, 6);
   endfunction

   // well-formed packet with items in random order, checksum mostly last
   function automatic void build_random_packet();
      item_kind_type kinds[$];
      int            n;
      int            i;
      logic [7:0]    ber;
      if ($urandom_range(0, 3) == 0) ber = 8'h80 | 8'($urandom_range(0, MAX_BER_BYTES_DEF));
      else ber = 8'($urandom_range(0, 127));
      begin_packet(ber);
      if ($urandom_range(0, 15) != 0) kinds.push_back(ITEM_TIMESTAMP);
      if ($urandom_range(0, 15) != 0)
         kinds.insert($urandom_range(0, kinds.size()), ITEM_VERSION);
      n = $urandom_range(0, 3);
      repeat (n) kinds.insert($urandom_range(0, kinds.size()), ITEM_OTHER);
      case ($urandom_range(0, 15))
         0: ;
         1, 2: kinds.insert($urandom_range(0, kinds.size()), ITEM_CHECKSUM);
         default: kinds.push_back(ITEM_CHECKSUM);
      endcase
      for (i = 0; i < kinds.size(); i++) begin
         case (kinds[i])
            ITEM_TIMESTAMP: add_item(shadow_cfg.timestamp_tag, rand_len());
            ITEM_VERSION:   add_item(shadow_cfg.version_tag, rand_len());
            ITEM_OTHER:     add_item(rand_byte(), rand_len());
            default:        add_checksum();
         endcase
      end
   endfunction

   function automatic logic [7:0] pick_tag();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hff;
         default: return rand_byte();
      endcase
   endfunction

   function automatic logic [63:0] pick_key_half();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.key_upper     = pick_key_half();
      c.key_lower     = pick_key_half();
      c.checksum_tag  = pick_tag();
      c.timestamp_tag = pick_tag();
      c.version_tag   = pick_tag();
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------------

   // one byte transaction; entered and left just after a falling edge
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, fin};
      do @(posedge clock); while (!req_ready);
      predict_byte(b, fin);
      @(negedge clock);
   endtask

   task automatic send_packet();
      int i;
      for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
      pkt.delete();
   endtask

   // drop valid, let every awaited result arrive and the pipeline empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // all five registers; tag writes carry junk above the tag byte
   task automatic load_config(input cfg_type c);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_KEY_UPPER, c.key_upper);
      write_reg(CSR_KEY_LOWER, c.key_lower);
      write_reg(CSR_CHECKSUM_TAG, {junk[63:8], c.checksum_tag});
      write_reg(CSR_TIMESTAMP_TAG, {junk[55:0], c.timestamp_tag});
      write_reg(CSR_VERSION_TAG, {junk[63:16], junk[7:0], c.version_tag});
      csr_we     <= 1'b0;
      shadow_cfg  = c;
   endtask

   // result side: random stall bursts while idling is on
   initial begin
      @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("value_valid", want.value_valid, rsp_data.value_valid);
            check_field("item_tag", want.item_tag, rsp_data.item_tag);
            check_field("value_offset", want.value_offset, rsp_data.value_offset);
            check_field("value_data", want.value_data, rsp_data.value_data);
            check_field("item_last", want.item_last, rsp_data.item_last);
            check_field("packet_done", want.packet_done, rsp_data.packet_done);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset registers: zero key, default tags, a clean packet
   task automatic test_reset_defaults();
      begin_packet(8'h0a);
      add_mandatory();
      add_checksum();
      send_packet();
      wait_idle();
   endtask

   task automatic test_wrong_key();
      // mismatch part way through the key, rest of the packet ignored
      begin_packet(8'h05);
      add_mandatory();
      add_checksum();
      pkt[5] = pkt[5] ^ 8'h80;
      send_packet();
      // mismatch on the last key byte
      begin_packet(8'h05);
      add_item(shadow_cfg.timestamp_tag, 3);
      pkt[15] = pkt[15] ^ 8'h01;
      send_packet();
      // one-byte packets: mismatch on the final byte, then a good key byte cut short
      pkt.push_back(~key_byte(0));
      send_packet();
      pkt.push_back(key_byte(0));
      send_packet();
      wait_idle();
   endtask

   // short and long ber forms, over-long length and an end inside the length
   task automatic test_length_forms();
      cfg_type    c;
      logic [7:0] forms[$];
      int         i;
      c.key_upper     = '1;
      c.key_lower     = '1;
      c.checksum_tag  = 8'hff;
      c.timestamp_tag = 8'h00;
      c.version_tag   = 8'h80;
      load_config(c);
      forms = '{8'h7f, 8'h00, 8'h80, 8'h81, 8'h88};
      for (i = 0; i < forms.size(); i++) begin
         begin_packet(forms[i]);
         add_mandatory();
         add_checksum();
         send_packet();
      end
      begin_packet(8'h89);
      add_mandatory();
      send_packet();
      // over-long length on the very last byte
      begin_packet(8'hff);
      send_packet();
      begin_packet(8'h84);
      void'(pkt.pop_back());
      void'(pkt.pop_back());
      send_packet();
      wait_idle();
   endtask

   // the missing-item and checksum statuses, and packets cut short on a key, tag or value byte
   task automatic test_status_codes();
      cfg_type c;
      c.key_upper     = {$urandom, $urandom};
      c.key_lower     = {$urandom, $urandom};
      c.checksum_tag  = CHECKSUM_TAG_RST;
      c.timestamp_tag = TIMESTAMP_TAG_RST;
      c.version_tag   = VERSION_TAG_RST;
      load_config(c);
      begin_packet(8'h05);
      add_item(shadow_cfg.version_tag, 2);
      add_checksum();
      send_packet();
      begin_packet(8'h05);
      add_item(shadow_cfg.timestamp_tag, 8);
      add_checksum();
      send_packet();
      begin_packet(8'h05);
      add_mandatory();
      send_packet();
      // checksum item present but all zero
      begin_packet(8'h05);
      add_mandatory();
      pkt.push_back(shadow_cfg.checksum_tag);
      pkt.push_back(8'd2);
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      send_packet();
      // an item after the checksum spoils it
      begin_packet(8'h05);
      add_mandatory();
      add_checksum();
      add_item(8'h30, 1);
      send_packet();
      // ends on the last key byte
      begin_packet(8'h05);
      void'(pkt.pop_back());
      send_packet();
      // ends on a tag byte
      begin_packet(8'h05);
      add_mandatory();
      pkt.push_back(8'h10);
      send_packet();
      // ends inside a value
      begin_packet(8'h05);
      add_mandatory();
      add_item(8'h10, 4);
      void'(pkt.pop_back());
      void'(pkt.pop_back());
      send_packet();
      wait_idle();
   endtask

   // zero-length items, the longest item, shared tags, repeated checksum items
   task automatic test_item_shapes();
      cfg_type c;
      c.key_upper     = {$urandom, $urandom};
      c.key_lower     = {$urandom, $urandom};
      c.checksum_tag  = 8'h07;
      c.timestamp_tag = 8'h07;
      c.version_tag   = 8'h07;
      load_config(c);
      // one zero-length item with the shared tag marks timestamp and version seen
      begin_packet(8'h03);
      add_item(8'h07, 0);
      add_item(8'h20, 0);
      add_item(8'h21, 255);
      add_checksum();
      send_packet();
      // two checksum items feed one received sum
      begin_packet(8'h03);
      add_item(8'h07, 1);
      add_item(8'h07, 1);
      send_packet();
      wait_idle();
      c.checksum_tag  = 8'h80;
      c.timestamp_tag = 8'hff;
      c.version_tag   = 8'h00;
      load_config(c);
      begin_packet(8'h00);
      add_item(8'h00, 2);
      add_item(8'hff, 0);
      add_checksum();
      send_packet();
      wait_idle();
   endtask

   // mostly well-formed packets with random content, some broken, some noise
   task automatic test_random();
      int random_bytes;
      int packets;
      int pos;
      random_bytes = 0;
      packets      = 0;
      while (random_bytes < RANDOM_BYTES) begin
         if (packets % 6 == 0) begin
            wait_idle();
            load_config(random_config());
         end
         packets++;
         if (random_bytes > RANDOM_BYTES - CALM_BYTES) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            7: begin
               build_random_packet();
               case ($urandom_range(0, 2))
                  0: begin
                     // cut short at a random byte
                     pos = $urandom_range(1, pkt.size() - 1);
                     while (pkt.size() > pos) void'(pkt.pop_back());
                  end
                  1: begin
                     pos = $urandom_range(0, pkt.size() - 1);
                     pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
                  end
                  default: pkt[KEY_BYTES] = 8'($urandom_range(8'h89, 8'hff));
               endcase
               random_bytes += pkt.size();
            end
            8: begin
               // line noise: almost always a wrong key
               pkt.delete();
               repeat ($urandom_range(1, 8)) pkt.push_back(rand_byte());
            end
            9: begin
               build_random_packet();
               pos = $urandom_range(0, KEY_BYTES - 1);
               pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
            end
            default: begin
               build_random_packet();
               random_bytes += pkt.size();
            end
         endcase
         send_packet();
      end
      wait_idle();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      shadow_cfg.key_upper     = '0;
      shadow_cfg.key_lower     = '0;
      shadow_cfg.checksum_tag  = CHECKSUM_TAG_RST;
      shadow_cfg.timestamp_tag = TIMESTAMP_TAG_RST;
      shadow_cfg.version_tag   = VERSION_TAG_RST;
      clear_packet();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_wrong_key();
      test_length_forms();
      test_status_codes();
      test_item_shapes();
      test_random();

      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
